/* hdl/bpoc_pkg.sv */
// Package: shared constants and codes for the box push-out collision core.
`default_nettype none
package bpoc_pkg;
  localparam int unsigned FracBits  = 8;
  localparam int unsigned CoordW    = 24;
  localparam int unsigned SizeW     = 10;
  localparam int unsigned RadW      = 18;
  // wide working width for differences and multiplier operands
  localparam int unsigned WideW     = 28;
  localparam int unsigned SqW       = 56;
  localparam int unsigned RootW     = 28;
  localparam int unsigned QuotW     = 48;
  localparam int unsigned DivIter   = 48;
  localparam int unsigned CntW      = 6;

  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_CIRCLE = 2'd1,
    FUNC_SQUARE = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [0:0] {
    REG_BOX_WIDTH  = 1'b0,
    REG_BOX_HEIGHT = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_SQ1,
    ST_SQ2,
    ST_TEST,
    ST_ROOT,
    ST_PEN,
    ST_MULX,
    ST_DIVX,
    ST_MULY,
    ST_DIVY,
    ST_SQUARE,
    ST_DONE
  } state_e;
endpackage
`default_nettype wire

/* hdl/box_push_out_collision_core.sv */
// Top level: box centre keeper resolving circle and square obstacle collisions.
//
// Usage: requests arrive on s_axis (func on tuser; position, radius and side on
// tdata); each request produces exactly one result on m_axis (new centre plus
// pushed and centre_inside flags). Box size is set through the cfg write port
// while no request is in flight.
//
// A load or unused code goes from prep to done; a square obstacle passes one
// square step. A circle that misses stops after the overlap test, one whose centre
// sits in the box after the root; one that pushes runs a restoring square root
// (28 steps) and two restoring divisions (48 steps each), which share one
// subtract-compare unit, and one 28x28 multiplier is reused for the squares and
// the push products. One request at a time: s_axis_tready is high only in the
// idle state, so a request is accepted only once the last has left done.
// Reset: centre goes to (0,0), box size to 32 x 32 units, no result pending.
// Stall: the result stays registered on m_axis until taken; the next request
// may be accepted meanwhile, but its result waits in the done state until the
// output register is free.
`default_nettype none
module box_push_out_collision_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [1:0] func
  input  wire logic [1:0]  s_axis_tuser,
  // [23:0] pos_x, [47:24] pos_y, [65:48] circle_radius, [75:66] square_side,
  // [79:76] zero
  input  wire logic [79:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [23:0] centre_x, [47:24] centre_y, [48] pushed, [49] centre_inside, [55:50] zero
  output logic [55:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [9:0]  cfg_data_i
);
  localparam int unsigned W  = bpoc_pkg::WideW;
  localparam int unsigned F  = bpoc_pkg::FracBits;
  localparam int unsigned CW = bpoc_pkg::CoordW;

  bpoc_pkg::state_e state_q, state_d;

  logic [9:0] box_w_q, box_h_q;
  logic signed [CW-1:0] box_x_q, box_y_q, box_x_d, box_y_d;
  logic signed [CW-1:0] ox_q, oy_q;
  logic [1:0]           func_q;
  logic signed [CW-1:0] px_q, py_q;
  logic [17:0]          rad_q;
  logic [9:0]           side_q;
  logic signed [W-1:0]  dx_q, dy_q, dx_d, dy_d;
  logic [bpoc_pkg::SqW-1:0] acc_q, acc_d;   // d2, then remainder of sqrt/div
  logic [bpoc_pkg::SqW-1:0] r2_q, r2_d;
  logic [bpoc_pkg::RootW-1:0] root_q, root_d;
  logic [bpoc_pkg::QuotW-1:0] quo_q, quo_d, num_q, num_d;
  logic                 nneg_q, nneg_d;
  logic [W-1:0]         pen_q, pen_d;
  logic [bpoc_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                 inside_q, inside_d;
  logic                 out_v_q;
  logic [55:0]          out_q, out_d;
  logic                 out_load;

  logic in_acc, out_acc;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // box half and full extents in fixed point
  logic signed [W-1:0] hw, hh, fw, fh, side_f;
  assign hw = W'({box_w_q[9:1], F'(0)});
  assign hh = W'({box_h_q[9:1], F'(0)});
  assign fw = W'({box_w_q, F'(0)});
  assign fh = W'({box_h_q, F'(0)});
  assign side_f = W'({side_q, F'(0)});

  logic signed [W-1:0] bx, by, pxw, pyw;
  assign bx  = W'(box_x_q);
  assign by  = W'(box_y_q);
  assign pxw = W'(px_q);
  assign pyw = W'(py_q);

  // shared multiplier, operands selected by state
  logic signed [W-1:0] mul_a, mul_b;
  logic signed [2*W-1:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // shared subtract-compare unit
  logic [bpoc_pkg::SqW:0] sub_a, sub_b, sub_r;
  assign sub_r = sub_a - sub_b;

  // saturating add of a signed offset to a coordinate
  function automatic logic signed [CW-1:0] sat_add(logic signed [CW-1:0] a,
                                                   logic signed [49:0] b);
    logic signed [50:0] s;
    s = 51'(a) + 51'(b);
    if (s > 51'(bpoc_pkg::CoordMax)) sat_add = bpoc_pkg::CoordMax;
    else if (s < 51'(bpoc_pkg::CoordMin)) sat_add = bpoc_pkg::CoordMin;
    else sat_add = s[CW-1:0];
  endfunction

  // square obstacle terms
  logic signed [W-1:0] left, top, ol, orr, ot, ob, mx, my, amx, amy;
  logic hit;
  always_comb begin
    left = bx - hw;
    top  = by - hh;
    hit  = (left < pxw + side_f) && (left + fw > pxw) &&
           (top < pyw + side_f) && (top + fh > pyw);
    ol   = (bx + hw) - pxw;
    orr  = (pxw + side_f) - left;
    ot   = (by + hh) - pyw;
    ob   = (pyw + side_f) - top;
    mx   = (ol < orr) ? ol : -orr;
    my   = (ot < ob) ? ot : -ob;
    amx  = mx[W-1] ? -mx : mx;
    amy  = my[W-1] ? -my : my;
  end

  // clamp of circle centre into box
  logic signed [W-1:0] cx, cy;
  always_comb begin
    cx = (pxw < bx - hw) ? bx - hw : pxw;
    cx = (cx > bx + hw) ? bx + hw : cx;
    cy = (pyw < by - hh) ? by - hh : pyw;
    cy = (cy > by + hh) ? by + hh : cy;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bpoc_pkg::ST_IDLE:   if (in_acc) state_d = bpoc_pkg::ST_PREP;
      bpoc_pkg::ST_PREP: begin
        case (bpoc_pkg::func_e'(func_q))
          bpoc_pkg::FUNC_CIRCLE: state_d = bpoc_pkg::ST_SQ1;
          bpoc_pkg::FUNC_SQUARE: state_d = bpoc_pkg::ST_SQUARE;
          default:               state_d = bpoc_pkg::ST_DONE;
        endcase
      end
      bpoc_pkg::ST_SQ1:    state_d = bpoc_pkg::ST_SQ2;
      bpoc_pkg::ST_SQ2:    state_d = bpoc_pkg::ST_TEST;
      bpoc_pkg::ST_TEST:
        state_d = (acc_q < r2_q) ? bpoc_pkg::ST_ROOT : bpoc_pkg::ST_DONE;
      bpoc_pkg::ST_ROOT:
        if (cnt_q == bpoc_pkg::CntW'(1)) state_d = bpoc_pkg::ST_PEN;
      bpoc_pkg::ST_PEN:
        state_d = (root_q == '0) ? bpoc_pkg::ST_DONE : bpoc_pkg::ST_MULX;
      bpoc_pkg::ST_MULX:   state_d = bpoc_pkg::ST_DIVX;
      bpoc_pkg::ST_DIVX:   if (cnt_q == bpoc_pkg::CntW'(1)) state_d = bpoc_pkg::ST_MULY;
      bpoc_pkg::ST_MULY:   state_d = bpoc_pkg::ST_DIVY;
      bpoc_pkg::ST_DIVY:   if (cnt_q == bpoc_pkg::CntW'(1)) state_d = bpoc_pkg::ST_DONE;
      bpoc_pkg::ST_SQUARE: state_d = bpoc_pkg::ST_DONE;
      bpoc_pkg::ST_DONE:   if (!out_v_q || out_acc) state_d = bpoc_pkg::ST_IDLE;
      default:             state_d = bpoc_pkg::ST_IDLE;
    endcase
  end

  // datapath
  logic [bpoc_pkg::SqW-1:0] q_add;
  logic signed [49:0] push;
  always_comb begin
    box_x_d = box_x_q; box_y_d = box_y_q;
    dx_d = dx_q; dy_d = dy_q;
    acc_d = acc_q; r2_d = r2_q; root_d = root_q;
    quo_d = quo_q; num_d = num_q; nneg_d = nneg_q;
    pen_d = pen_q; cnt_d = cnt_q; inside_d = inside_q;
    mul_a = dx_q; mul_b = dx_q;
    sub_a = '0; sub_b = '0;
    q_add = '0; push = '0;
    out_load = 1'b0;
    case (state_q)
      bpoc_pkg::ST_IDLE: begin
        inside_d = 1'b0;
      end
      bpoc_pkg::ST_PREP: begin
        if (bpoc_pkg::func_e'(func_q) == bpoc_pkg::FUNC_LOAD) begin
          box_x_d = px_q; box_y_d = py_q;
        end
        dx_d = cx - pxw;
        dy_d = cy - pyw;
        // multiplier is free here: radius squared
        mul_a = W'(rad_q); mul_b = W'(rad_q);
        r2_d  = mul_p[bpoc_pkg::SqW-1:0];
      end
      bpoc_pkg::ST_SQ1: begin
        acc_d = mul_p[bpoc_pkg::SqW-1:0];
      end
      bpoc_pkg::ST_SQ2: begin
        mul_a = dy_q; mul_b = dy_q;
        acc_d = acc_q + mul_p[bpoc_pkg::SqW-1:0];
      end
      bpoc_pkg::ST_TEST: begin
        // start root: bit pairs of d2 come from r2, remainder in acc
        root_d = '0;
        cnt_d  = bpoc_pkg::CntW'(bpoc_pkg::RootW);
        r2_d   = acc_q;   // keep d2 for bit pairs
        acc_d  = '0;
      end
      bpoc_pkg::ST_ROOT: begin
        // remainder = rem*4 + next pair of d2
        q_add = {acc_q[bpoc_pkg::SqW-3:0], r2_q[bpoc_pkg::SqW-1 -: 2]};
        sub_a = {1'b0, q_add};
        sub_b = {1'b0, 26'(0), root_q, 2'b01};
        if (!sub_r[bpoc_pkg::SqW]) begin
          acc_d  = sub_r[bpoc_pkg::SqW-1:0];
          root_d = {root_q[bpoc_pkg::RootW-2:0], 1'b1};
        end else begin
          acc_d  = q_add;
          root_d = {root_q[bpoc_pkg::RootW-2:0], 1'b0};
        end
        r2_d  = {r2_q[bpoc_pkg::SqW-3:0], 2'b00};
        cnt_d = cnt_q - 1'b1;
      end
      bpoc_pkg::ST_PEN: begin
        pen_d = W'(rad_q) - W'(root_q);
        if (root_q == '0) inside_d = 1'b1;
      end
      bpoc_pkg::ST_MULX, bpoc_pkg::ST_MULY: begin
        mul_a = (state_q == bpoc_pkg::ST_MULX) ? dx_q : dy_q;
        mul_b = pen_q;
        nneg_d = mul_p[2*W-1];
        // magnitude plus half divisor for round to nearest
        num_d = bpoc_pkg::QuotW'(mul_p[2*W-1] ? -mul_p : mul_p) +
                bpoc_pkg::QuotW'(root_q[bpoc_pkg::RootW-1:1]);
        acc_d = '0;
        quo_d = '0;
        cnt_d = bpoc_pkg::CntW'(bpoc_pkg::DivIter);
      end
      bpoc_pkg::ST_DIVX, bpoc_pkg::ST_DIVY: begin
        sub_a = {1'b0, acc_q[bpoc_pkg::SqW-2:0], num_q[bpoc_pkg::QuotW-1]};
        sub_b = {1'b0, 28'(0), root_q};
        if (!sub_r[bpoc_pkg::SqW]) begin
          acc_d = sub_r[bpoc_pkg::SqW-1:0];
          quo_d = {quo_q[bpoc_pkg::QuotW-2:0], 1'b1};
        end else begin
          acc_d = sub_a[bpoc_pkg::SqW-1:0];
          quo_d = {quo_q[bpoc_pkg::QuotW-2:0], 1'b0};
        end
        num_d = {num_q[bpoc_pkg::QuotW-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == bpoc_pkg::CntW'(1)) begin
          push = nneg_q ? -50'(quo_d) : 50'(quo_d);
          if (state_q == bpoc_pkg::ST_DIVX) box_x_d = sat_add(box_x_q, push);
          else                              box_y_d = sat_add(box_y_q, push);
        end
      end
      bpoc_pkg::ST_SQUARE: begin
        if (hit) begin
          if (amx < amy) box_x_d = sat_add(box_x_q, -50'(mx));
          else           box_y_d = sat_add(box_y_q, -50'(my));
        end
      end
      bpoc_pkg::ST_DONE: begin
        out_load = !out_v_q || out_acc;
      end
      default: ;
    endcase
  end

  logic pushed;
  assign pushed = (func_q == bpoc_pkg::FUNC_CIRCLE || func_q == bpoc_pkg::FUNC_SQUARE) &&
                  (box_x_q != ox_q || box_y_q != oy_q);
  assign out_d = {6'd0, inside_q, pushed, box_y_q, box_x_q};

  // outputs
  always_comb begin
    s_axis_tready = (state_q == bpoc_pkg::ST_IDLE);
    m_axis_tvalid = out_v_q;
    m_axis_tdata  = out_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bpoc_pkg::ST_IDLE;
      box_w_q  <= 10'd32;
      box_h_q  <= 10'd32;
      box_x_q  <= '0;
      box_y_q  <= '0;
      out_v_q  <= 1'b0;
      cnt_q    <= '0;
      inside_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      box_x_q  <= box_x_d;
      box_y_q  <= box_y_d;
      cnt_q    <= cnt_d;
      inside_q <= inside_d;
      if (out_load)     out_v_q <= 1'b1;
      else if (out_acc) out_v_q <= 1'b0;
      if (cfg_we_i) begin
        if (bpoc_pkg::reg_e'(cfg_index_i) == bpoc_pkg::REG_BOX_WIDTH) box_w_q <= cfg_data_i;
        else                                                          box_h_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= s_axis_tuser;
      px_q   <= s_axis_tdata[23:0];
      py_q   <= s_axis_tdata[47:24];
      rad_q  <= s_axis_tdata[65:48];
      side_q <= s_axis_tdata[75:66];
      ox_q   <= box_x_q;
      oy_q   <= box_y_q;
    end
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    acc_q  <= acc_d;
    r2_q   <= r2_d;
    root_q <= root_d;
    quo_q  <= quo_d;
    num_q  <= num_d;
    nneg_q <= nneg_d;
    pen_q  <= pen_d;
    if (out_load) out_q <= out_d;
  end

  // a new item is only taken while idle
  a_acc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == bpoc_pkg::ST_PREP) else $error("accept outside idle");
  // result goes valid only from the done state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(state_q) == bpoc_pkg::ST_DONE) else $error("stray result");
  // centre never moves while idle
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bpoc_pkg::ST_IDLE |=> $stable(box_x_q) && $stable(box_y_q))
    else $error("centre changed while idle");
endmodule
`default_nettype wire
